[rtl/psd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants and codes for the point to segment distance unit.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int REGION_WIDTH    = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_SEG_AX = 2'd0,
        CFG_SEG_AY = 2'd1,
        CFG_SEG_BX = 2'd2,
        CFG_SEG_BY = 2'd3
    } t_cfg_index;

    typedef enum logic [REGION_WIDTH-1:0] {
        REGION_BEYOND_B = 2'd0,
        REGION_BEFORE_A = 2'd1,
        REGION_BETWEEN  = 2'd2
    } t_region;

endpackage

[rtl/point_segment_distance_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_unit
// Distance from a streamed query point to a configured 2D segment.
// ----------------------------------------------------------------------------
// One point beat is taken every cycle unless the result side stalls. The
// distance is formed by a one-bit-per-stage square root pipeline followed
// by a one-bit-per-stage restoring divider. Three front stages form the
// differences, the products and the sums, and an output register closes
// the pipeline. A stall on the result side holds the whole pipeline.
// Region 0 means beyond end B, 1 before start A, 2 between the ends (also
// used for a degenerate segment, giving |EA|). The user must write segment
// endpoints only while no beat is in flight; the block does not enforce it.
module point_segment_distance_unit
    import psd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // config
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [COORD_WIDTH-1:0]     i_cfg_wdata,
    // point stream
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // point_x, point_y
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // result stream
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // distance
    output logic [((COORD_WIDTH+8)/8)*8-1:0]   o_m_tdata,
    // region
    output logic [REGION_WIDTH-1:0]    o_m_tuser
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int SW  = 2 * DW;
    localparam int OTW = ((COORD_WIDTH + 8) / 8) * 8;
    localparam int NPL = 3 + DW + SW;

    logic ce;
    logic [NPL:0] r_vld;

    // segment registers
    logic signed [COORD_WIDTH-1:0] r_ax, r_ay, r_bx, r_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0;
            r_ay <= '0;
            r_bx <= '0;
            r_by <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SEG_AX: r_ax <= i_cfg_wdata;
                CFG_SEG_AY: r_ay <= i_cfg_wdata;
                CFG_SEG_BX: r_bx <= i_cfg_wdata;
                CFG_SEG_BY: r_by <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign ce         = !(r_vld[NPL] && !i_m_tready);
    assign o_s_tready = ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[NPL-1:0], i_s_tvalid};
        end
    end

    // stage 1: differences
    logic signed [COORD_WIDTH-1:0] ex, ey;
    logic signed [DW-1:0] r1_abx, r1_aby, r1_aex, r1_aey, r1_bex, r1_bey;

    assign ex = i_s_tdata[COORD_WIDTH-1:0];
    assign ey = i_s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_abx <= DW'(r_bx) - DW'(r_ax);
            r1_aby <= DW'(r_by) - DW'(r_ay);
            r1_aex <= DW'(ex) - DW'(r_ax);
            r1_aey <= DW'(ey) - DW'(r_ay);
            r1_bex <= DW'(ex) - DW'(r_bx);
            r1_bey <= DW'(ey) - DW'(r_by);
        end
    end

    // stage 2: products
    logic signed [SW-1:0] r2_db0, r2_db1, r2_da0, r2_da1, r2_cr0, r2_cr1;
    logic signed [SW-1:0] r2_bx2, r2_by2, r2_ax2, r2_ay2, r2_sx2, r2_sy2;
    logic                 r2_degen;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r2_db0   <= r1_abx * r1_bex;
            r2_db1   <= r1_aby * r1_bey;
            r2_da0   <= r1_abx * r1_aex;
            r2_da1   <= r1_aby * r1_aey;
            r2_cr0   <= r1_abx * r1_aey;
            r2_cr1   <= r1_aby * r1_aex;
            r2_bx2   <= r1_bex * r1_bex;
            r2_by2   <= r1_bey * r1_bey;
            r2_ax2   <= r1_aex * r1_aex;
            r2_ay2   <= r1_aey * r1_aey;
            r2_sx2   <= r1_abx * r1_abx;
            r2_sy2   <= r1_aby * r1_aby;
            r2_degen <= (r1_abx == '0) && (r1_aby == '0);
        end
    end

    // stage 3: sums and region select
    logic signed [SW-1:0] dot_b, dot_a, cross_ab;
    t_region              n3_region;
    logic                 n3_div;
    logic [SW-1:0]        n3_rad;
    t_region              r3_region;
    logic                 r3_div;
    logic [SW-1:0]        r3_rad, r3_cross;

    assign dot_b    = r2_db0 + r2_db1;
    assign dot_a    = r2_da0 + r2_da1;
    assign cross_ab = r2_cr0 - r2_cr1;

    always_comb begin
        if (dot_b > 0) begin
            n3_region = REGION_BEYOND_B;
            n3_div    = 1'b0;
            n3_rad    = r2_bx2 + r2_by2;
        end else if (dot_a < 0) begin
            n3_region = REGION_BEFORE_A;
            n3_div    = 1'b0;
            n3_rad    = r2_ax2 + r2_ay2;
        end else begin
            n3_region = REGION_BETWEEN;
            n3_div    = !r2_degen;
            n3_rad    = r2_degen ? (r2_ax2 + r2_ay2) : (r2_sx2 + r2_sy2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r3_region <= n3_region;
            r3_div    <= n3_div;
            r3_rad    <= n3_rad;
            r3_cross  <= cross_ab[SW-1] ? SW'(-cross_ab) : cross_ab;
        end
    end

    // square root: one root bit per stage
    logic [DW+1:0]     r_sq_rem   [0:DW];
    logic [DW-1:0]     r_sq_root  [0:DW];
    logic [SW-1:0]     r_sq_rad   [0:DW];
    logic [SW-1:0]     r_sq_cross [0:DW];
    t_region           r_sq_reg   [0:DW];
    logic              r_sq_div   [0:DW];

    always_comb begin
        r_sq_rem[0]   = '0;
        r_sq_root[0]  = '0;
        r_sq_rad[0]   = r3_rad;
        r_sq_cross[0] = r3_cross;
        r_sq_reg[0]   = r3_region;
        r_sq_div[0]   = r3_div;
    end

    for (genvar k = 0; k < DW; k++) begin : g_sqrt
        logic [DW+1:0] pre, trial;
        logic          ge;

        assign pre   = {r_sq_rem[k][DW-1:0], r_sq_rad[k][SW-1-2*k -: 2]};
        assign trial = {r_sq_root[k], 2'b01};
        assign ge    = pre >= trial;

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_sq_rem[k+1]   <= ge ? (pre - trial) : pre;
                r_sq_root[k+1]  <= {r_sq_root[k][DW-2:0], ge};
                r_sq_rad[k+1]   <= r_sq_rad[k];
                r_sq_cross[k+1] <= r_sq_cross[k];
                r_sq_reg[k+1]   <= r_sq_reg[k];
                r_sq_div[k+1]   <= r_sq_div[k];
            end
        end
    end

    // restoring divide: one quotient bit per stage
    logic [DW-1:0] r_dv_rem   [0:SW];
    logic [SW-1:0] r_dv_q     [0:SW];
    logic [DW-1:0] r_dv_den   [0:SW];
    logic [SW-1:0] r_dv_num   [0:SW];
    t_region       r_dv_reg   [0:SW];
    logic          r_dv_div   [0:SW];

    always_comb begin
        r_dv_rem[0] = '0;
        r_dv_q[0]   = '0;
        r_dv_den[0] = r_sq_root[DW];
        r_dv_num[0] = r_sq_cross[DW];
        r_dv_reg[0] = r_sq_reg[DW];
        r_dv_div[0] = r_sq_div[DW];
    end

    for (genvar k = 0; k < SW; k++) begin : g_div
        logic [DW:0] pre, den;
        logic        ge;

        assign pre = {r_dv_rem[k], r_dv_num[k][SW-1-k]};
        assign den = {1'b0, r_dv_den[k]};
        assign ge  = pre >= den;

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_dv_rem[k+1] <= ge ? DW'(pre - den) : pre[DW-1:0];
                r_dv_q[k+1]   <= {r_dv_q[k][SW-2:0], ge};
                r_dv_den[k+1] <= r_dv_den[k];
                r_dv_num[k+1] <= r_dv_num[k];
                r_dv_reg[k+1] <= r_dv_reg[k];
                r_dv_div[k+1] <= r_dv_div[k];
            end
        end
    end

    // output register
    logic [DW-1:0] n_dist, r_dist;
    t_region       r_region;

    always_comb begin
        if (!r_dv_div[SW]) begin
            n_dist = r_dv_den[SW];
        end else if (r_dv_q[SW][SW-1:DW] != '0) begin
            n_dist = '1;
        end else begin
            n_dist = r_dv_q[SW][DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dist   <= n_dist;
            r_region <= r_dv_reg[SW];
        end
    end

    assign o_m_tvalid = r_vld[NPL];
    assign o_m_tdata  = OTW'(r_dist);
    assign o_m_tuser  = r_region;

endmodule

[tb/sv/psd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_checker
// Watches the point and result streams of the segment distance unit. For each
// accepted point beat it computes the expected distance and region from its
// own copy of the segment registers and compares them, in order, with the
// result beats.
// ----------------------------------------------------------------------------
module psd_checker
    import psd_pkg::*;
#(
    parameter int CW = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]         i_cfg_index,
    input  logic [CW-1:0]                      i_cfg_wdata,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    // point_x, point_y
    input  logic [((2*CW+7)/8)*8-1:0]          i_s_tdata,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    // distance
    input  logic [((CW+8)/8)*8-1:0]            i_m_tdata,
    // region
    input  logic [REGION_WIDTH-1:0]            i_m_tuser,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked
);

    localparam int DW = CW + 1;

    typedef struct packed {
        logic [DW-1:0] distance;
        t_region       region;
    } t_dist_result;

    logic signed [CW-1:0] seg_ax, seg_ay, seg_bx, seg_by;
    t_dist_result         expected_q[$];
    int                   region_seen[3];

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] length_of(input longint dx, input longint dy);
        return root_floor(64'(dx * dx + dy * dy));
    endfunction

    function automatic t_dist_result segment_distance(input logic signed [CW-1:0] ex,
                                                      input logic signed [CW-1:0] ey);
        longint      abx, aby, aex, aey, bex, bey, dot_b, dot_a, cr;
        logic [63:0] d, s;
        t_dist_result r;
        abx   = longint'(seg_bx) - longint'(seg_ax);
        aby   = longint'(seg_by) - longint'(seg_ay);
        aex   = longint'(ex) - longint'(seg_ax);
        aey   = longint'(ey) - longint'(seg_ay);
        bex   = longint'(ex) - longint'(seg_bx);
        bey   = longint'(ey) - longint'(seg_by);
        dot_b = abx * bex + aby * bey;
        dot_a = abx * aex + aby * aey;
        if (dot_b > 0) begin
            r.region = REGION_BEYOND_B;
            d = length_of(bex, bey);
        end else if (dot_a < 0) begin
            r.region = REGION_BEFORE_A;
            d = length_of(aex, aey);
        end else begin
            r.region = REGION_BETWEEN;
            if (abx == 0 && aby == 0) begin
                d = length_of(aex, aey);
            end else begin
                cr = abx * aey - aby * aex;
                if (cr < 0) cr = -cr;
                s = length_of(abx, aby);
                if (s == 0) s = 1;
                d = 64'(cr) / s;
            end
        end
        if (d > {DW{1'b1}}) d = {DW{1'b1}};
        r.distance = d[DW-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    task automatic show_summary();
        $display("  regions checked: beyond B %0d, before A %0d, between %0d",
                 region_seen[0], region_seen[1], region_seen[2]);
    endtask

    assign o_pending = expected_q.size();

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
    end

    always @(posedge i_clk) begin
        t_dist_result exp_r;
        if (!i_rst_n) begin
            seg_ax <= '0;
            seg_ay <= '0;
            seg_bx <= '0;
            seg_by <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_SEG_AX: seg_ax <= i_cfg_wdata;
                    CFG_SEG_AY: seg_ay <= i_cfg_wdata;
                    CFG_SEG_BX: seg_bx <= i_cfg_wdata;
                    CFG_SEG_BY: seg_by <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_q.push_back(segment_distance(i_s_tdata[CW-1:0],
                                                      i_s_tdata[2*CW-1:CW]));
            end
            if (i_m_tvalid && i_m_tready) begin
                o_checked++;
                if (expected_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.region <= REGION_BETWEEN) region_seen[exp_r.region]++;
                    if (i_m_tdata[DW-1:0] !== exp_r.distance)
                        report_mismatch($sformatf("distance got %0d exp %0d",
                                                  i_m_tdata[DW-1:0], exp_r.distance));
                    if (i_m_tdata[$bits(i_m_tdata)-1:DW] !== '0)
                        report_mismatch("nonzero tdata padding");
                    if (i_m_tuser !== exp_r.region)
                        report_mismatch($sformatf("region got %0d exp %0d",
                                                  i_m_tuser, exp_r.region));
                end
            end
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the point to segment distance unit: directed points at the
// coordinate extremes and around the segment ends, then random points over
// several segment settings, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import psd_pkg::*;

    localparam int CW      = COORD_WIDTH_DEF;
    localparam int LATENCY = 4 + (CW + 1) + (2 * CW + 2);
    localparam int IDLE_LIMIT = 20000;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_wr_en;
    logic [CFG_INDEX_WIDTH-1:0]         i_cfg_index;
    logic [CW-1:0]                      i_cfg_wdata;
    logic                               i_s_tvalid;
    logic                               o_s_tready;
    logic [((2*CW+7)/8)*8-1:0]          i_s_tdata;
    logic                               o_m_tvalid;
    logic                               i_m_tready;
    logic [((CW+8)/8)*8-1:0]            o_m_tdata;
    logic [REGION_WIDTH-1:0]            o_m_tuser;
    int                                 fail_count, pending, checked;
    int                                 idle_cycles;
    int                                 points_sent;
    logic                               sink_busy;

    point_segment_distance_unit #(.COORD_WIDTH(CW)) u_top (.*);

    psd_checker #(.CW(CW)) u_checker (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_index, .i_cfg_wdata,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // result side stall
    initial begin
        int g;
        i_m_tready = 1'b0;
        sink_busy  = 1'b1;
        @(posedge i_clk);
        forever begin
            g = sink_busy ? gap_len() : 0;
            if (g > 0) begin
                i_m_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            i_cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("** point_segment_distance_unit: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_index idx, input logic [CW-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic set_segment(input logic [CW-1:0] ax, input logic [CW-1:0] ay,
                               input logic [CW-1:0] bx, input logic [CW-1:0] by);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        write_reg(CFG_SEG_AX, ax);
        write_reg(CFG_SEG_AY, ay);
        write_reg(CFG_SEG_BX, bx);
        write_reg(CFG_SEG_BY, by);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_point(input logic [CW-1:0] px, input logic [CW-1:0] py,
                              input bit allow_gap);
        int g;
        g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= $bits(i_s_tdata)'({py, px});
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        points_sent++;
    endtask

    function automatic logic [CW-1:0] rand_coord(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return CW'($urandom());
        if (r == 1) return $urandom_range(0, 1) ? CMAX : CMIN;
        return CW'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic random_points(input int n, input int span, input bit noisy);
        logic [CW-1:0] ax, ay;
        for (int k = 0; k < n; k++) begin
            ax = rand_coord(span);
            ay = rand_coord(span);
            send_point(ax, ay, noisy || ($urandom_range(0, 3) == 0));
        end
        i_s_tvalid <= 1'b0;
    endtask

    initial begin
        int span;
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        points_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset segment: degenerate at origin
        send_point(CMAX, CMAX, 0);
        send_point(CMIN, CMIN, 0);
        send_point('0, '0, 0);
        i_s_tvalid <= 1'b0;

        // horizontal segment, points at both ends, between and beyond
        set_segment(-CW'(2560), '0, CW'(2560), '0);
        send_point(CW'(2560), CW'(768), 0);
        send_point(-CW'(2560), -CW'(768), 0);
        send_point(CW'(2561), '0, 0);
        send_point(-CW'(2561), '0, 1);
        send_point('0, CW'(1000), 0);
        send_point(CMAX, CMIN, 0);
        send_point(CMIN, CMAX, 0);
        i_s_tvalid <= 1'b0;

        // extreme endpoints across the whole range
        set_segment(CMIN, CMIN, CMAX, CMAX);
        send_point(CMIN, CMAX, 0);
        send_point(CMAX, CMIN, 0);
        send_point(CMAX, CMAX, 0);
        send_point(CMIN, CMIN, 0);
        send_point('0, '0, 0);
        i_s_tvalid <= 1'b0;

        // very short segment: large quotients from a unit divisor
        set_segment('0, '0, CW'(1), '0);
        send_point('0, CMAX, 0);
        send_point('0, CMIN, 0);
        send_point('0, CW'(5), 0);
        i_s_tvalid <= 1'b0;

        // degenerate off origin
        set_segment(CMAX, CMIN, CMAX, CMIN);
        send_point(CMIN, CMAX, 0);
        send_point(CMAX, CMIN, 0);
        i_s_tvalid <= 1'b0;

        sink_busy = 1'b0;
        random_points(100, 1 << 12, 0);
        sink_busy = 1'b1;

        for (int ph = 0; ph < 9; ph++) begin
            span = (ph % 3 == 0) ? (1 << 23) - 1 : (ph % 3 == 1) ? (1 << 14) : (1 << 8);
            set_segment(rand_coord(span), rand_coord(span), rand_coord(span),
                        rand_coord(span));
            random_points(200, span, ph % 2);
        end

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("  %0d point beats sent, %0d result beats checked over 14 segments",
                 points_sent, checked);
        u_checker.show_summary();
        if (fail_count == 0 && pending == 0) begin
            $display("** point_segment_distance_unit: PASSED **");
        end else begin
            $display("** point_segment_distance_unit: FAILED **");
        end
        $finish;
    end

endmodule
